// ===== design/btds_pkg.sv =====
// Shared types and constants for the byte translate/delete/squeeze filter.
package btds_pkg;

    localparam int ByteW     = 8;
    localparam int TableD    = 1 << ByteW;
    localparam int TdataInW  = 24;
    localparam int CfgAddrW  = 4;
    localparam int CfgDataW  = 32;

    typedef logic [ByteW-1:0] byte_t;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_MAP  = 2'd1,
        OP_DEL  = 2'd2,
        OP_SQZ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_TRANSLATE = 2'd0,
        REG_DELETE    = 2'd1,
        REG_SQUEEZE   = 2'd2,
        REG_KEEP_NUL  = 2'd3
    } reg_idx_t;

    // Table write request
    typedef struct packed {
        logic  map_we;
        logic  del_we;
        logic  sqz_we;
        byte_t addr;
        byte_t data;
    } tbl_wr_t;

    // Registered table read results
    typedef struct packed {
        byte_t map_byte;
        logic  del_flag;
        logic  sqz_flag;
    } tbl_rd_t;

endpackage

// ===== design/btds_tables.sv =====
// Translation map, delete flags and squeeze flags with registered reads.
module btds_tables (
    input  logic                aclk,
    input  logic                aresetn,
    input  btds_pkg::tbl_wr_t   wr,
    input  logic                rd_a_en,
    input  btds_pkg::byte_t     rd_a_addr,
    input  logic                rd_b_en,
    input  btds_pkg::byte_t     rd_b_addr,
    output btds_pkg::tbl_rd_t   rd,
    output logic                ready
);

    btds_pkg::byte_t map_mem [btds_pkg::TableD];
    logic            del_mem [btds_pkg::TableD];
    logic            sqz_mem [btds_pkg::TableD];

    // Clearing pass after reset: one entry of every table per cycle
    logic            clr_busy_reg;
    btds_pkg::byte_t clr_idx_reg;

    btds_pkg::byte_t map_rd_reg;
    logic            del_rd_reg;
    logic            sqz_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + btds_pkg::byte_t'(1);
            if (clr_idx_reg == '1) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign ready = !clr_busy_reg;

    // Reload identity map and clear flags while busy, else take load writes
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            map_mem[clr_idx_reg] <= clr_idx_reg;
            del_mem[clr_idx_reg] <= 1'b0;
            sqz_mem[clr_idx_reg] <= 1'b0;
        end else begin
            if (wr.map_we) begin
                map_mem[wr.addr] <= wr.data;
            end
            if (wr.del_we) begin
                del_mem[wr.addr] <= wr.data[0];
            end
            if (wr.sqz_we) begin
                sqz_mem[wr.addr] <= wr.data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_a_en) begin
            map_rd_reg <= map_mem[rd_a_addr];
            del_rd_reg <= del_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            sqz_rd_reg <= sqz_mem[rd_b_addr];
        end
    end

    assign rd.map_byte = map_rd_reg;
    assign rd.del_flag = del_rd_reg;
    assign rd.sqz_flag = sqz_rd_reg;

endmodule

// ===== design/byte_translate_delete_squeeze_core.sv =====
// Top level: tr-style byte filter with translate, delete and squeeze steps.
// An input transfer passes through the stage 1, stage 2 and result registers to its result transfer.
// Throughput: one item per cycle while m_tready holds; a transfer that yields no result leaves a bubble.
// The map and delete tables are read at input accept, the squeeze table one stage later.
// Reset (synchronous, aresetn low): flags, mode and last-byte registers clear; then a
// clearing pass over all 256 entries reloads the identity map and clear flags, s_tready held low.
module byte_translate_delete_squeeze_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [btds_pkg::TdataInW-1:0]     s_tdata,   // op[1:0], byte_in[9:2], load_value[17:10]
    input  logic                              s_tuser,   // first
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [btds_pkg::ByteW-1:0]        m_tdata,   // byte_out[7:0]
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [btds_pkg::CfgAddrW-1:0]     paddr,
    input  logic [btds_pkg::CfgDataW-1:0]     pwdata,
    output logic [btds_pkg::CfgDataW-1:0]     prdata,
    output logic                              pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic translate_on_reg;
    logic delete_on_reg;
    logic squeeze_on_reg;
    logic keep_nul_reg;

    btds_pkg::reg_idx_t cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = btds_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            translate_on_reg <= 1'b0;
            delete_on_reg    <= 1'b0;
            squeeze_on_reg   <= 1'b0;
            keep_nul_reg     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                btds_pkg::REG_TRANSLATE: translate_on_reg <= pwdata[0];
                btds_pkg::REG_DELETE:    delete_on_reg    <= pwdata[0];
                btds_pkg::REG_SQUEEZE:   squeeze_on_reg   <= pwdata[0];
                btds_pkg::REG_KEEP_NUL:  keep_nul_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            btds_pkg::REG_TRANSLATE: prdata[0] = translate_on_reg;
            btds_pkg::REG_DELETE:    prdata[0] = delete_on_reg;
            btds_pkg::REG_SQUEEZE:   prdata[0] = squeeze_on_reg;
            btds_pkg::REG_KEEP_NUL:  prdata[0] = keep_nul_reg;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when the slot below is free
    // or moving, so an empty stage keeps input flowing during a stall.
    // Hold input off until the table clearing pass is done.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, out_valid_reg;
    logic en_out, en2, en1;
    logic s_accept;
    logic tbl_ready;

    assign en_out   = !out_valid_reg || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1 && tbl_ready;
    assign s_accept = s_tvalid && s_tready;

    // Unpack the input transfer
    btds_pkg::op_t   in_op;
    btds_pkg::byte_t in_byte;
    btds_pkg::byte_t in_load;

    assign in_op   = btds_pkg::op_t'(s_tdata[1:0]);
    assign in_byte = s_tdata[9:2];
    assign in_load = s_tdata[17:10];

    // ------------------------------------------------------------------
    // Tables: loads write at accept, so a data byte right behind a load
    // already sees the new entry at its own read.
    // ------------------------------------------------------------------
    btds_pkg::tbl_wr_t tbl_wr;
    btds_pkg::tbl_rd_t tbl_rd;
    btds_pkg::byte_t   c1;

    assign tbl_wr.map_we = s_accept && (in_op == btds_pkg::OP_MAP);
    assign tbl_wr.del_we = s_accept && (in_op == btds_pkg::OP_DEL);
    assign tbl_wr.sqz_we = s_accept && (in_op == btds_pkg::OP_SQZ);
    assign tbl_wr.addr   = in_byte;
    assign tbl_wr.data   = in_load;

    btds_tables u_tables (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (tbl_wr),
        .rd_a_en   (en1),
        .rd_a_addr (in_byte),
        .rd_b_en   (en2),
        .rd_b_addr (c1),
        .rd        (tbl_rd),
        .ready     (tbl_ready)
    );

    // ------------------------------------------------------------------
    // Stage 1: NUL drop, translate or delete
    // ------------------------------------------------------------------
    logic            data1_reg;
    logic            first1_reg;
    btds_pkg::byte_t b1_reg;
    logic            drop1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            data1_reg  <= (in_op == btds_pkg::OP_DATA);
            first1_reg <= s_tuser;
            b1_reg     <= in_byte;
        end
    end

    assign c1 = translate_on_reg ? tbl_rd.map_byte : b1_reg;

    always_comb begin
        drop1 = 1'b0;
        if (b1_reg == '0 && !keep_nul_reg) begin
            drop1 = 1'b1;
        end else if (translate_on_reg) begin
            drop1 = (c1 == '0) && !keep_nul_reg;
        end else if (delete_on_reg) begin
            drop1 = tbl_rd.del_flag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squeeze against the last emitted byte
    // ------------------------------------------------------------------
    logic            live2_reg;
    logic            first2_reg;
    btds_pkg::byte_t c2_reg;
    btds_pkg::byte_t last_byte_reg;
    logic            last_valid_reg;
    logic            last_eff;
    logic            emit2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            live2_reg  <= data1_reg && !drop1;
            first2_reg <= data1_reg && first1_reg;
            c2_reg     <= c1;
        end
    end

    // A first bit forgets the last byte before the compare
    assign last_eff = last_valid_reg && !first2_reg;
    assign emit2    = live2_reg &&
                      !(squeeze_on_reg && last_eff && (c2_reg == last_byte_reg) &&
                        tbl_rd.sqz_flag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_byte_reg  <= '0;
            last_valid_reg <= 1'b0;
        end else if (v2_reg && en_out) begin
            if (emit2) begin
                last_byte_reg  <= c2_reg;
                last_valid_reg <= 1'b1;
            end else if (first2_reg) begin
                last_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    btds_pkg::byte_t byte_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en_out) begin
            out_valid_reg <= v2_reg && emit2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            byte_out_reg <= c2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = byte_out_reg;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the tr-style byte translate/delete/squeeze filter.
module tb;

    localparam int WatchdogLimit = 4000;
    // Margin to drain the pipeline; bubbles can still be in flight after the last result.
    localparam int DrainCycles   = 8;
    localparam int RandPhases    = 8;
    localparam int ItemsPerPhase = 150;

    // One input transfer, as the filter sees it
    typedef struct packed {
        btds_pkg::op_t   op;
        btds_pkg::byte_t val;
        btds_pkg::byte_t load;
        logic            first;
    } filt_item_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [btds_pkg::TdataInW-1:0] s_tdata  = '0;  // op[1:0], byte_in[9:2], load_value[17:10]
    logic                          s_tuser  = 1'b0; // first
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [btds_pkg::ByteW-1:0]    m_tdata;         // byte_out[7:0]
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [btds_pkg::CfgAddrW-1:0] paddr    = '0;
    logic [btds_pkg::CfgDataW-1:0] pwdata   = '0;
    logic [btds_pkg::CfgDataW-1:0] prdata;
    logic                          pready;

    byte_translate_delete_squeeze_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Filter predictor: its own copy of the tables, the last-byte memory
    // and the four mode bits.
    // ------------------------------------------------------------------
    btds_pkg::byte_t map_tbl [btds_pkg::TableD];
    bit              del_flag[btds_pkg::TableD];
    bit              sqz_flag[btds_pkg::TableD];
    btds_pkg::byte_t last_out;
    bit              last_ok;
    bit              xlate_on, del_on, sqz_on, keep_nul;

    btds_pkg::byte_t out_bytes_q[$];   // surviving bytes still owed by the block
    filt_item_t      item_q[$];        // items waiting for the driver

    int n_pushed, n_accepted, n_emitted, n_dropped, n_loads, n_results, n_errors;
    int n_cfg_writes;

    // Apply one accepted item to the predictor; queue the byte it should emit, if any.
    function automatic void filter_step(input filt_item_t it);
        btds_pkg::byte_t c;
        bit              keep;
        case (it.op)
            btds_pkg::OP_MAP: begin
                map_tbl[it.val] = it.load;
                n_loads++;
            end
            btds_pkg::OP_DEL: begin
                del_flag[it.val] = it.load[0];
                n_loads++;
            end
            btds_pkg::OP_SQZ: begin
                sqz_flag[it.val] = it.load[0];
                n_loads++;
            end
            default: begin
                if (it.first)
                    last_ok = 1'b0;
                c    = it.val;
                keep = 1'b1;
                if (c == 8'h00 && !keep_nul) begin
                    keep = 1'b0;
                end else if (xlate_on) begin
                    // translation wins over deletion when both modes are on
                    c = map_tbl[c];
                    if (c == 8'h00 && !keep_nul)
                        keep = 1'b0;
                end else if (del_on && del_flag[c]) begin
                    keep = 1'b0;
                end
                // squeeze compares and looks up the flag by the translated byte
                if (keep && sqz_on && last_ok && c == last_out && sqz_flag[c])
                    keep = 1'b0;
                if (keep) begin
                    last_out = c;
                    last_ok  = 1'b1;
                    out_bytes_q.push_back(c);
                    n_emitted++;
                end else begin
                    n_dropped++;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps.
    // src_hold keeps the sender quiet while the initial block waits.
    // ------------------------------------------------------------------
    filt_item_t cur_item;
    int         burst_left, gap_left;
    bit         src_hold = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // predict on the transfer that completes at this edge
            if (s_tvalid && s_tready) begin
                filter_step(cur_item);
                n_accepted++;
            end
            // hold the current item while it is stalled; otherwise pick the next one
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (src_hold || item_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    cur_item = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(btds_pkg::TdataInW-18){1'b0}}, cur_item.load,
                                 cur_item.val, cur_item.op};
                    s_tuser  <= cur_item.first;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // start a new burst; about one in four bursts runs on with no gap
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall on a random pattern that is redrawn whenever its timer runs out.
    // ------------------------------------------------------------------
    int stall_pct, stall_timer;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_pct   = 0;
            stall_timer = 0;
        end else begin
            if (stall_timer == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                stall_timer = $urandom_range(20, 200);
            end else begin
                stall_timer--;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each result transfer with the oldest owed byte.
    always @(posedge aclk) begin
        btds_pkg::byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (out_bytes_q.size() == 0) begin
                $error("byte_out: no result expected, actual %h", m_tdata);
                n_errors++;
            end else begin
                want = out_bytes_q.pop_front();
                if (m_tdata !== want) begin
                    $error("byte_out mismatch: expected %h, actual %h", want, m_tdata);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input btds_pkg::op_t op, input btds_pkg::byte_t val,
                            input btds_pkg::byte_t load, input logic first);
        filt_item_t it;
        it.op    = op;
        it.val   = val;
        it.load  = load;
        it.first = first;
        item_q.push_back(it);
        n_pushed++;
    endtask

    // Wait until every item is taken and every owed byte has come back, then let
    // the pipeline empty of bubbles.
    task automatic settle();
        src_hold = 1'b0;
        while (n_accepted != n_pushed || out_bytes_q.size() != 0)
            @(posedge aclk);
        src_hold = 1'b1;
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // APB write of one mode bit, then read it back.
    task automatic cfg_write(input btds_pkg::reg_idx_t idx, input bit v);
        logic [btds_pkg::CfgAddrW-1:0] addr;
        addr = btds_pkg::CfgAddrW'({idx, 2'b00});
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(btds_pkg::CfgDataW-1){1'b0}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            btds_pkg::REG_TRANSLATE: xlate_on = v;
            btds_pkg::REG_DELETE:    del_on   = v;
            btds_pkg::REG_SQUEEZE:   sqz_on   = v;
            default:                 keep_nul = v;
        endcase
        n_cfg_writes++;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[0] !== v) begin
            $error("register %s readback: expected %0d, actual %0d", idx.name(), v,
                   prdata[0]);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_modes(input bit t, input bit d, input bit s, input bit k);
        cfg_write(btds_pkg::REG_TRANSLATE, t);
        cfg_write(btds_pkg::REG_DELETE, d);
        cfg_write(btds_pkg::REG_SQUEEZE, s);
        cfg_write(btds_pkg::REG_KEEP_NUL, k);
    endtask

    // Small alphabet so that runs, squeezes and table hits are common.
    btds_pkg::byte_t alpha[8] = '{8'h00, 8'h20, 8'h41, 8'h42, 8'h61, 8'h62, 8'h7F, 8'hFF};
    btds_pkg::byte_t prev_val = 8'h41;

    task automatic add_random_item();
        int              r;
        btds_pkg::byte_t v, l;
        r = $urandom_range(0, 99);
        v = ($urandom_range(0, 1) == 0) ? alpha[3'($urandom_range(0, 7))]
                                        : btds_pkg::byte_t'($urandom_range(0, 255));
        l = btds_pkg::byte_t'($urandom_range(0, 255));
        if (r < 12) begin
            // mapping to NUL now and then exercises the mapped-NUL drop
            if ($urandom_range(0, 9) == 0)
                l = 8'h00;
            add_item(btds_pkg::OP_MAP, v, l, 1'b0);
        end else if (r < 20) begin
            add_item(btds_pkg::OP_DEL, v, l, 1'($urandom_range(0, 1)));
        end else if (r < 28) begin
            add_item(btds_pkg::OP_SQZ, v, l, 1'($urandom_range(0, 1)));
        end else begin
            // repeat the previous data byte often to build runs
            if ($urandom_range(0, 2) == 0)
                v = prev_val;
            prev_val = v;
            add_item(btds_pkg::OP_DATA, v, l, ($urandom_range(0, 19) == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        bit t, d, s, k;
        for (int i = 0; i < btds_pkg::TableD; i++) begin
            map_tbl[i]  = btds_pkg::byte_t'(i);
            del_flag[i] = 1'b0;
            sqz_flag[i] = 1'b0;
        end
        last_out = 8'h00;
        last_ok  = 1'b0;
        xlate_on = 1'b0;
        del_on   = 1'b0;
        sqz_on   = 1'b0;
        keep_nul = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset modes: NUL dropped, other bytes pass; loads on every op, flag loads
        // with upper bits set or a clear bit 0.
        add_item(btds_pkg::OP_DATA, 8'h00, 8'hFF, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'hFF, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h01, 8'hFF, 1'b1);
        add_item(btds_pkg::OP_DATA, 8'hAA, 8'h55, 1'b0);
        add_item(btds_pkg::OP_MAP,  8'h61, 8'h00, 1'b1);
        add_item(btds_pkg::OP_MAP,  8'hFF, 8'h41, 1'b0);
        add_item(btds_pkg::OP_MAP,  8'h00, 8'h7E, 1'b0);
        add_item(btds_pkg::OP_DEL,  8'h62, 8'hFE, 1'b0);
        add_item(btds_pkg::OP_DEL,  8'h63, 8'h01, 1'b1);
        add_item(btds_pkg::OP_SQZ,  8'h41, 8'hFF, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h41, 8'h00, 1'b0);
        settle();

        // Translate and squeeze: mapped NUL drops, squeeze acts on the mapped byte,
        // first reopens a run.
        set_modes(1'b1, 1'b0, 1'b1, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h61, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'hFF, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'hFF, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h41, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h41, 8'h00, 1'b1);
        add_item(btds_pkg::OP_DATA, 8'h00, 8'h00, 1'b0);
        settle();

        // Both modes on with NULs kept: translation alone acts.
        set_modes(1'b1, 1'b1, 1'b0, 1'b1);
        add_item(btds_pkg::OP_DATA, 8'h00, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h61, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h63, 8'h00, 1'b0);
        settle();

        // Delete only: the flagged byte goes, the byte loaded with a clear bit 0 stays.
        cfg_write(btds_pkg::REG_TRANSLATE, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h63, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h62, 8'h00, 1'b0);
        add_item(btds_pkg::OP_DATA, 8'h00, 8'h00, 1'b0);
        settle();

        // Random phases: all modes on, all off, then random settings. Each phase
        // ends by waiting until every owed byte is back, then pauses the sender.
        for (int ph = 0; ph < RandPhases; ph++) begin
            if (ph == 0) begin
                set_modes(1'b1, 1'b1, 1'b1, 1'b1);
            end else if (ph == 1) begin
                set_modes(1'b0, 1'b0, 1'b0, 1'b0);
            end else begin
                t = 1'($urandom_range(0, 1));
                d = 1'($urandom_range(0, 1));
                s = 1'($urandom_range(0, 1));
                k = 1'($urandom_range(0, 1));
                set_modes(t, d, s, k);
            end
            for (int i = 0; i < ItemsPerPhase; i++)
                add_random_item();
            settle();
        end

        $display("Covered %0d transfers (%0d table loads), %0d register writes.",
                 n_accepted, n_loads, n_cfg_writes);
        $display("Filter kept %0d bytes and dropped %0d; %0d results checked.",
                 n_emitted, n_dropped, n_results);
        if (n_errors == 0 && out_bytes_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
